// ----- hw/rtl/scp_pkg.sv -----
// Package for the serial command parser: result codes, character constants,
// keyword strings and small helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

	localparam int CMD_MAX_DEF = 12;

	typedef logic [2:0] cmd_code_t;

	localparam cmd_code_t CMD_SCAN     = 3'd0;
	localparam cmd_code_t CMD_ADC      = 3'd1;
	localparam cmd_code_t CMD_LEDON    = 3'd2;
	localparam cmd_code_t CMD_LEDOFF   = 3'd3;
	localparam cmd_code_t CMD_UNKNOWN  = 3'd4;
	localparam cmd_code_t CMD_BAD_ARGS = 3'd5;
	localparam cmd_code_t CMD_TOO_LONG = 3'd6;

	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Keywords are stored left-justified in six character slots.
	localparam logic [47:0] WORD_SCAN   = {"SCAN", 16'h0000};
	localparam logic [47:0] WORD_ADC    = {"ADC", 24'h000000};
	localparam logic [47:0] WORD_LEDON  = {"LEDON", 8'h00};
	localparam logic [47:0] WORD_LEDOFF = "LEDOFF";

	localparam logic [2:0] LEN_SCAN   = 3'd4;
	localparam logic [2:0] LEN_ADC    = 3'd3;
	localparam logic [2:0] LEN_LEDON  = 3'd5;
	localparam logic [2:0] LEN_LEDOFF = 3'd6;

	localparam int ARG_W = 18;
	localparam logic [ARG_W+3:0] ARG_SAT = 22'd131072;
	localparam logic [ARG_W-1:0] ARG_POS_MAX = 18'd131071;

	typedef struct packed {
		logic       clr;
		logic       step;
		logic       set_sign;
		logic       neg;
		logic [3:0] digit;
	} arg_ctrl_t;

	function automatic logic [7:0] char_at(input logic [47:0] word, input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = word[47:40];
			3'd1: c = word[39:32];
			3'd2: c = word[31:24];
			3'd3: c = word[23:16];
			3'd4: c = word[15:8];
			3'd5: c = word[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scp_arg_acc.sv -----
// Decimal accumulator: multiplies by ten and adds one digit per step,
// saturating, and applies the sign at the end. Depends on scp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp_arg_acc (
	input  wire logic                         clk,
	input  wire scp_pkg::arg_ctrl_t           ctrl,
	output logic [scp_pkg::ARG_W-1:0]         value
);

	logic [scp_pkg::ARG_W-1:0] acc_q;
	logic                      neg_q;
	logic [scp_pkg::ARG_W+3:0] next_acc;

	assign next_acc = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{scp_pkg::ARG_W{1'b0}}, ctrl.digit};

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (ctrl.step) begin
				acc_q <= (next_acc > scp_pkg::ARG_SAT) ? scp_pkg::ARG_SAT[scp_pkg::ARG_W-1:0]
					: next_acc[scp_pkg::ARG_W-1:0];
			end
			if (ctrl.set_sign) begin
				neg_q <= ctrl.neg;
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			value = '0 - acc_q;
		end else if (acc_q > scp_pkg::ARG_POS_MAX) begin
			value = scp_pkg::ARG_POS_MAX;
		end else begin
			value = acc_q;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scp_tokenizer.sv -----
// Sequencer that reads the stored command one byte per cycle, splits it into
// tokens, matches the keyword and drives the argument accumulator.
// Depends on scp_pkg and scp_arg_acc.
`timescale 1ns / 1ps
`default_nettype none

module scp_tokenizer #(
	parameter int MAX_CMD_CHARS = scp_pkg::CMD_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [$clog2(MAX_CMD_CHARS)-1:0] count,
	input  wire logic [7:0]                       rdata,
	output logic      [$clog2(MAX_CMD_CHARS)-1:0] raddr,
	output logic                                  busy,
	output logic                                  done,
	output scp_pkg::cmd_code_t                    res_code,
	output logic      [scp_pkg::ARG_W-1:0]        res_arg
);

	localparam int IDX_W = $clog2(MAX_CMD_CHARS);

	typedef enum logic [1:0] {
		TS_IDLE = 2'b01,
		TS_SCAN = 2'b10
	} tok_state_t;

	typedef enum logic [3:0] {
		PH_SKIP1 = 4'b0001,
		PH_TOK1  = 4'b0010,
		PH_SKIP2 = 4'b0100,
		PH_ARG   = 4'b1000
	} phase_t;

	tok_state_t         state_q, state_d;
	phase_t             phase_q, phase_d;
	logic [IDX_W-1:0]   idx_q, cnt_q, cnt_cur;
	logic               pend_q, issue, more;
	logic [2:0]         tlen_q, tlen_d;
	logic               m_scan_q, m_adc_q, m_ledon_q, m_ledoff_q;
	logic               m_scan_d, m_adc_d, m_ledon_d, m_ledoff_d;
	logic               ws_q, ws_d, stop_q, stop_d;
	scp_pkg::cmd_code_t led_code_q, led_code_d;
	scp_pkg::cmd_code_t tok1_code;
	logic               tok1_led;
	logic               delim, is_digit, is_ws, is_sign;
	scp_pkg::arg_ctrl_t ctrl;
	logic [scp_pkg::ARG_W-1:0] arg_value;

	scp_arg_acc u_acc (
		.clk   (clk),
		.ctrl  (ctrl),
		.value (arg_value)
	);

	assign busy    = (state_q != TS_IDLE);
	assign raddr   = idx_q;
	assign cnt_cur = (state_q == TS_IDLE) ? count : cnt_q;
	assign more    = (idx_q < cnt_cur);

	assign delim    = scp_pkg::is_delim(rdata);
	assign is_digit = (rdata >= scp_pkg::CH_ZERO) && (rdata <= scp_pkg::CH_NINE);
	assign is_ws    = (rdata == scp_pkg::CH_TAB) || (rdata == scp_pkg::CH_VT)
		|| (rdata == scp_pkg::CH_FF);
	assign is_sign  = (rdata == scp_pkg::CH_PLUS) || (rdata == scp_pkg::CH_MINUS);

	always_comb begin
		tok1_led = 1'b0;
		if ((tlen_q == scp_pkg::LEN_SCAN) && m_scan_q) begin
			tok1_code = scp_pkg::CMD_SCAN;
		end else if ((tlen_q == scp_pkg::LEN_ADC) && m_adc_q) begin
			tok1_code = scp_pkg::CMD_ADC;
		end else if ((tlen_q == scp_pkg::LEN_LEDON) && m_ledon_q) begin
			tok1_code = scp_pkg::CMD_LEDON;
			tok1_led  = 1'b1;
		end else if ((tlen_q == scp_pkg::LEN_LEDOFF) && m_ledoff_q) begin
			tok1_code = scp_pkg::CMD_LEDOFF;
			tok1_led  = 1'b1;
		end else begin
			tok1_code = scp_pkg::CMD_UNKNOWN;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		tlen_d     = tlen_q;
		m_scan_d   = m_scan_q;
		m_adc_d    = m_adc_q;
		m_ledon_d  = m_ledon_q;
		m_ledoff_d = m_ledoff_q;
		ws_d       = ws_q;
		stop_d     = stop_q;
		led_code_d = led_code_q;
		ctrl       = '0;
		ctrl.digit = rdata[3:0];
		ctrl.neg   = (rdata == scp_pkg::CH_MINUS);
		issue      = 1'b0;
		done       = 1'b0;
		res_code   = scp_pkg::CMD_UNKNOWN;
		case (state_q)
			TS_IDLE: begin
				if (start) begin
					state_d  = TS_SCAN;
					phase_d  = PH_SKIP1;
					ctrl.clr = 1'b1;
					ws_d     = 1'b1;
					stop_d   = 1'b0;
					issue    = more;
				end
			end
			TS_SCAN: begin
				if (!pend_q) begin
					done = 1'b1;
					case (phase_q)
						PH_SKIP1: res_code = scp_pkg::CMD_UNKNOWN;
						PH_TOK1:  res_code = tok1_led ? scp_pkg::CMD_BAD_ARGS : tok1_code;
						PH_SKIP2: res_code = scp_pkg::CMD_BAD_ARGS;
						PH_ARG:   res_code = led_code_q;
						default:  res_code = scp_pkg::CMD_UNKNOWN;
					endcase
				end else begin
					case (phase_q)
						PH_SKIP1: begin
							if (!delim) begin
								phase_d    = PH_TOK1;
								tlen_d     = 3'd1;
								m_scan_d   = (rdata == scp_pkg::char_at(scp_pkg::WORD_SCAN, 3'd0));
								m_adc_d    = (rdata == scp_pkg::char_at(scp_pkg::WORD_ADC, 3'd0));
								m_ledon_d  = (rdata == scp_pkg::char_at(scp_pkg::WORD_LEDON, 3'd0));
								m_ledoff_d = (rdata == scp_pkg::char_at(scp_pkg::WORD_LEDOFF, 3'd0));
							end
						end
						PH_TOK1: begin
							if (delim) begin
								if (tok1_led) begin
									phase_d    = PH_SKIP2;
									led_code_d = tok1_code;
								end else begin
									done     = 1'b1;
									res_code = tok1_code;
								end
							end else begin
								if (tlen_q != 3'd7) begin
									tlen_d = tlen_q + 3'd1;
								end
								m_scan_d   = m_scan_q && (tlen_q < scp_pkg::LEN_SCAN)
									&& (rdata == scp_pkg::char_at(scp_pkg::WORD_SCAN, tlen_q));
								m_adc_d    = m_adc_q && (tlen_q < scp_pkg::LEN_ADC)
									&& (rdata == scp_pkg::char_at(scp_pkg::WORD_ADC, tlen_q));
								m_ledon_d  = m_ledon_q && (tlen_q < scp_pkg::LEN_LEDON)
									&& (rdata == scp_pkg::char_at(scp_pkg::WORD_LEDON, tlen_q));
								m_ledoff_d = m_ledoff_q && (tlen_q < scp_pkg::LEN_LEDOFF)
									&& (rdata == scp_pkg::char_at(scp_pkg::WORD_LEDOFF, tlen_q));
							end
						end
						PH_SKIP2, PH_ARG: begin
							if (delim) begin
								if (phase_q == PH_ARG) begin
									done     = 1'b1;
									res_code = led_code_q;
								end
							end else begin
								phase_d = PH_ARG;
								if (!stop_q) begin
									if (is_digit) begin
										ctrl.step = 1'b1;
										ws_d      = 1'b0;
									end else if (ws_q && is_ws) begin
										ws_d = 1'b1;
									end else if (ws_q && is_sign) begin
										ctrl.set_sign = 1'b1;
										ws_d          = 1'b0;
									end else begin
										stop_d = 1'b1;
									end
								end
							end
						end
						default: begin
							done     = 1'b1;
							res_code = scp_pkg::CMD_UNKNOWN;
						end
					endcase
				end
				if (done) begin
					state_d = TS_IDLE;
				end else begin
					issue = more;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	assign res_arg = ((res_code == scp_pkg::CMD_LEDON) || (res_code == scp_pkg::CMD_LEDOFF))
		? arg_value : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
			phase_q <= PH_SKIP1;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			pend_q  <= issue;
			if (done) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == TS_IDLE) && start) begin
			cnt_q <= count;
		end
		tlen_q     <= tlen_d;
		m_scan_q   <= m_scan_d;
		m_adc_q    <= m_adc_d;
		m_ledon_q  <= m_ledon_d;
		m_ledoff_q <= m_ledoff_d;
		ws_q       <= ws_d;
		stop_q     <= stop_d;
		led_code_q <= led_code_d;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/serial_command_parser.sv -----
// Serial command parser top level: header detection, command byte store,
// tokenizer and result register. Depends on scp_pkg, scp_ram and scp_tokenizer.
//
// Usage: bytes enter on the input channel (in_valid, in_stall, rx_byte), one
// byte per transfer. While idle the block looks for the header "DB"; it then
// stores up to MAX_CMD_CHARS command bytes. A CR or LF ends the command and one
// result leaves on the output channel (out_valid, out_stall, command_code,
// argument). Filling the store without a terminator gives a too-long result.
// Ordinary bytes are taken without a stall. A terminator starts a scan of
// the stored bytes, one byte per cycle through the registered read port of the
// store, and in_stall stays high while the scan runs. A too-long result appears
// in the cycle after the transfer of the last byte. While a result waits in the
// output register and out_stall is high, in_stall is high as well and the
// result holds. Reset clears the header window, the byte count and the output
// valid flag; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_parser #(
	parameter int MAX_CMD_CHARS = scp_pkg::CMD_MAX_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         rx_byte,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output scp_pkg::cmd_code_t                      command_code,
	output logic signed [scp_pkg::ARG_W-1:0]        argument
);

	localparam int IDX_W = $clog2(MAX_CMD_CHARS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CMD_CHARS - 1);

	logic                       collecting_q;
	logic [7:0]                 prev_q;
	logic                       prev_valid_q;
	logic [IDX_W-1:0]           count_q;
	logic                       out_valid_q;
	scp_pkg::cmd_code_t         code_q;
	logic [scp_pkg::ARG_W-1:0]  arg_q;

	logic                       accept, is_term, header, start, we, too_long;
	logic [IDX_W-1:0]           raddr;
	logic [7:0]                 rdata;
	logic                       tok_busy, tok_done;
	scp_pkg::cmd_code_t         tok_code;
	logic [scp_pkg::ARG_W-1:0]  tok_arg;

	assign in_stall     = tok_busy || out_valid_q;
	assign accept       = in_valid && !in_stall;
	assign is_term      = (rx_byte == scp_pkg::CH_CR) || (rx_byte == scp_pkg::CH_LF);
	assign header       = accept && !collecting_q && prev_valid_q
		&& (prev_q == scp_pkg::CH_D) && (rx_byte == scp_pkg::CH_B);
	assign start        = accept && collecting_q && is_term;
	assign we           = accept && collecting_q && !is_term;
	assign too_long     = we && (count_q == LAST_IDX);

	assign out_valid    = out_valid_q;
	assign command_code = code_q;
	assign argument     = arg_q;

	scp_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CMD_CHARS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	scp_tokenizer #(
		.MAX_CMD_CHARS (MAX_CMD_CHARS)
	) u_tok (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.count    (count_q),
		.rdata    (rdata),
		.raddr    (raddr),
		.busy     (tok_busy),
		.done     (tok_done),
		.res_code (tok_code),
		.res_arg  (tok_arg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			prev_q       <= 8'h00;
			prev_valid_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (header) begin
				collecting_q <= 1'b1;
				prev_q       <= 8'h00;
				prev_valid_q <= 1'b0;
				count_q      <= '0;
			end else if (accept && !collecting_q) begin
				prev_q       <= rx_byte;
				prev_valid_q <= 1'b1;
			end else if (start || too_long) begin
				collecting_q <= 1'b0;
				count_q      <= '0;
			end else if (we) begin
				count_q <= count_q + 1'b1;
			end
			if (tok_done || too_long) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_done) begin
			code_q <= tok_code;
			arg_q  <= tok_arg;
		end else if (too_long) begin
			code_q <= scp_pkg::CMD_TOO_LONG;
			arg_q  <= '0;
		end
	end

endmodule

`default_nettype wire
